[rtl/core/pgig_pkg.sv]
// pgig_pkg: shared types, constants and ghost sequence tables for the
// periodic ghost image generator; depends on nothing
package pgig_pkg;

  localparam int unsigned COORD_W        = 32;
  localparam int unsigned LEN_W          = 31;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 31;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIN_WIDTH    = 3'd4;

  // axis select codes, one bit per shifted axis
  localparam logic [2:0] SEL_NONE = 3'b000;
  localparam logic [2:0] SEL_X    = 3'b001;
  localparam logic [2:0] SEL_Y    = 3'b010;
  localparam logic [2:0] SEL_Z    = 3'b100;
  localparam logic [2:0] SEL_XY   = 3'b011;
  localparam logic [2:0] SEL_XZ   = 3'b101;
  localparam logic [2:0] SEL_YZ   = 3'b110;
  localparam logic [2:0] SEL_XYZ  = 3'b111;

  typedef struct packed {
    logic [LEN_W-1:0] len_x;
    logic [LEN_W-1:0] len_y;
    logic [LEN_W-1:0] len_z;
    logic [LEN_W-1:0] skin;
    logic [2:0]       mask;
  } cfg_t;

  // one classified atom waiting for the back end
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] sz;
    logic [2:0]                flags;
  } entry_t;

  typedef logic [7:0][2:0] seq_t;

  // point order per flag set {z,y,x}; slot 0 is the atom itself
  function automatic seq_t pgig_seq(logic [2:0] flags);
    seq_t s;
    s = '0;
    unique case (flags)
      SEL_NONE: begin
        s[0] = SEL_NONE;
      end
      SEL_X: begin
        s[1] = SEL_X;
      end
      SEL_XY: begin
        s[1] = SEL_X; s[2] = SEL_XY; s[3] = SEL_Y;
      end
      SEL_XYZ: begin
        s[1] = SEL_X; s[2] = SEL_XY; s[3] = SEL_Y;
        s[4] = SEL_XYZ; s[5] = SEL_YZ; s[6] = SEL_XZ; s[7] = SEL_Z;
      end
      SEL_XZ: begin
        s[1] = SEL_X; s[2] = SEL_Z; s[3] = SEL_XZ;
      end
      SEL_Y: begin
        s[1] = SEL_Y;
      end
      SEL_YZ: begin
        s[1] = SEL_Y; s[2] = SEL_Z; s[3] = SEL_YZ;
      end
      SEL_Z: begin
        s[1] = SEL_Z;
      end
    endcase
    return s;
  endfunction

  // index of the final point for a flag set
  function automatic logic [2:0] pgig_last_idx(logic [2:0] flags);
    logic [2:0] n;
    unique case (flags)
      SEL_NONE: n = 3'd0;
      SEL_X:    n = 3'd1;
      SEL_Y:    n = 3'd1;
      SEL_Z:    n = 3'd1;
      SEL_XY:   n = 3'd3;
      SEL_XZ:   n = 3'd3;
      SEL_YZ:   n = 3'd3;
      SEL_XYZ:  n = 3'd7;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/pgig_stream_if.sv]
// pgig_stream_if: valid/ready channels for atoms in and points out
// depends on pgig_pkg for field widths
interface pgig_atom_if;
  import pgig_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface pgig_point_if;
  import pgig_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      is_ghost;
  logic                      last_of_atom;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output is_ghost, output last_of_atom, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input is_ghost, input last_of_atom, output ready);
endinterface

[rtl/core/pgig_front.sv]
// pgig_front: accepts atoms, flags edge axes and computes shifted images
// depends on pgig_pkg and pgig_atom_if
module pgig_front import pgig_pkg::*; (
  input  cfg_t             cfg_i,
  pgig_atom_if.sink        atom_i,
  input  logic             full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  typedef struct packed {
    logic                      flag;
    logic signed [COORD_W-1:0] shifted;
  } axis_res_t;

  function automatic axis_res_t axis_eval(logic periodic, logic signed [COORD_W-1:0] c,
                                          logic [LEN_W-1:0] len, logic [LEN_W-1:0] skin);
    logic signed [COORD_W+1:0] cw;
    logic signed [COORD_W+1:0] lw;
    logic signed [COORD_W+1:0] sw;
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] c2;
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W+1:0] dif;
    axis_res_t r;
    cw  = {{2{c[COORD_W-1]}}, c};
    lw  = {3'b000, len};
    sw  = {3'b000, skin};
    hi  = lw - sw;
    c2  = cw <<< 1;
    sum = cw + lw;
    dif = cw - lw;
    r.flag    = periodic && ((cw < sw) || (cw > hi));
    // below half the length moves up by one length, else down
    r.shifted = (c2 < lw) ? sum[COORD_W-1:0] : dif[COORD_W-1:0];
    return r;
  endfunction

  axis_res_t rx, ry, rz;

  always_comb begin
    rx = axis_eval(cfg_i.mask[0], atom_i.pos_x, cfg_i.len_x, cfg_i.skin);
    ry = axis_eval(cfg_i.mask[1], atom_i.pos_y, cfg_i.len_y, cfg_i.skin);
    rz = axis_eval(cfg_i.mask[2], atom_i.pos_z, cfg_i.len_z, cfg_i.skin);
  end

  assign atom_i.ready = !full_i;
  assign push_o       = atom_i.valid && !full_i;

  assign entry_o.x     = atom_i.pos_x;
  assign entry_o.y     = atom_i.pos_y;
  assign entry_o.z     = atom_i.pos_z;
  assign entry_o.sx    = rx.shifted;
  assign entry_o.sy    = ry.shifted;
  assign entry_o.sz    = rz.shifted;
  assign entry_o.flags = {rz.flag, ry.flag, rx.flag};

endmodule

[rtl/core/pgig_queue.sv]
// pgig_queue: short queue of classified atoms between front and back end
// depends on pgig_pkg for the entry type
module pgig_queue import pgig_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   head_valid_o,
  output logic   full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CNT_FULL);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/pgig_back.sv]
// pgig_back: walks the ghost sequence of the head atom, one point a cycle unless the output stalls
// depends on pgig_pkg and pgig_point_if
module pgig_back import pgig_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  pgig_point_if.source point_o
);

  logic [2:0]                idx_q, idx_d;
  logic                      valid_q, valid_d;
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic                      ghost_q, last_q;
  seq_t                      seq;
  logic [2:0]                sel;
  logic                      is_last;
  logic                      load;

  always_comb begin
    seq     = pgig_seq(head_i.flags);
    sel     = seq[idx_q];
    is_last = (idx_q == pgig_last_idx(head_i.flags));
    // output register takes a new word when empty or being drained
    load    = head_valid_i && (!valid_q || point_o.ready);
    pop_o   = load && is_last;
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = is_last ? 3'd0 : idx_q + 3'd1;
      valid_d = 1'b1;
    end else if (point_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q     <= sel[0] ? head_i.sx : head_i.x;
      y_q     <= sel[1] ? head_i.sy : head_i.y;
      z_q     <= sel[2] ? head_i.sz : head_i.z;
      ghost_q <= (idx_q != 3'd0);
      last_q  <= is_last;
    end
  end

  assign point_o.valid        = valid_q;
  assign point_o.out_x        = x_q;
  assign point_o.out_y        = y_q;
  assign point_o.out_z        = z_q;
  assign point_o.is_ghost     = ghost_q;
  assign point_o.last_of_atom = last_q;

endmodule

[rtl/core/periodic_ghost_image_generator_top.sv]
// periodic ghost image generator: atom in, atom plus periodic ghosts out
// a taken atom is queued, then each of its points is registered at the output
// throughput: one point per cycle unless the output stalls; an atom yields 1, 2, 4
// or 8 points, set by how many axes it flags
// reset: queue, sequencer and output valid cleared; all config registers read zero
module periodic_ghost_image_generator_top import pgig_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  pgig_atom_if.sink             atom_i,
  pgig_point_if.source          point_o
);

  cfg_t   cfg_q;
  entry_t entry, head;
  logic   push, pop, full, head_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELL_LEN_X:    cfg_q.len_x <= cfg_wdata_i[LEN_W-1:0];
        CFG_CELL_LEN_Y:    cfg_q.len_y <= cfg_wdata_i[LEN_W-1:0];
        CFG_CELL_LEN_Z:    cfg_q.len_z <= cfg_wdata_i[LEN_W-1:0];
        CFG_PERIODIC_MASK: cfg_q.mask  <= cfg_wdata_i[2:0];
        CFG_SKIN_WIDTH:    cfg_q.skin  <= cfg_wdata_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pgig_front u_front (
    .cfg_i   (cfg_q),
    .atom_i  (atom_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  pgig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (full)
  );

  pgig_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .point_o      (point_o)
  );

  // a full queue means the back end already holds a word
  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !atom_i.ready |-> point_o.valid)
    else $error("queue full with no output word");

  // an atom's sequence continues without a bubble
  a_no_gap_in_atom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.ready && !point_o.last_of_atom) |=> point_o.valid)
    else $error("gap inside an atom's point sequence");

  // the word after a final point starts a new atom
  a_atom_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.ready && point_o.last_of_atom)
      |=> (!point_o.valid || !point_o.is_ghost))
    else $error("ghost emitted before its atom");

  // after a non-final point is taken, the output holds a valid word or no ghost
  a_ghost_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.ready && !point_o.last_of_atom)
      |=> !point_o.is_ghost || point_o.valid)
    else $error("sequence broke after a non-final point");

endmodule
